/* rtl/b64d_pkg.sv */
// Package for the streaming Base64 decoder.
// Holds the item and packet types, code constants and the symbol classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Decoder modes
  localparam logic [1:0] MODE_SCAN = 2'd0;
  localparam logic [1:0] MODE_SEEK = 2'd1;
  localparam logic [1:0] MODE_OK   = 2'd2;
  localparam logic [1:0] MODE_ERR  = 2'd3;

  // Classifier flags (symbol values are 0..63)
  localparam logic [7:0] CLS_SPACE = 8'h40;
  localparam logic [7:0] CLS_ERROR = 8'h80;
  localparam logic [7:0] PAD_CHAR  = 8'h3D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [1:0]       kind;
    logic [POS_W-1:0] stop_position;
    logic             last_of_run;
  } out_item_t;

  // Everything one input item produces, queued between front and back
  typedef struct packed {
    logic [2:0][7:0]  data;
    logic [1:0]       n_data;
    logic             has_status;
    logic [1:0]       status_kind;
    logic [POS_W-1:0] status_pos;
  } pkt_t;

  // Map a text byte to its 6-bit symbol value, or a skip / error flag
  function automatic logic [7:0] b64d_classify(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      r = 8'd62;
    end else if (c == 8'h2F) begin
      r = 8'd63;
    end else if (c == 8'h08 || c == 8'h09 || c == 8'h0A || c == 8'h0C ||
                 c == 8'h0D || c == 8'h20 || c == 8'h27 || c == 8'hA0) begin
      r = CLS_SPACE;
    end else begin
      r = CLS_ERROR;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/base64_stream_decoder_top.sv */
// Streaming Base64 decoder, top level.
// Instantiates b64d_front, b64d_queue and b64d_back; uses b64d_pkg.
//
// Usage:
//   Input channel is queue-like: drive in_item_i and push; the byte is taken
//   at a clock edge where push is high and full is low. Results come out
//   queue-like: while empty is low out_item_o holds the oldest result, and
//   pop takes it. cfg_we_i writes the stop delimiter (zero disables it);
//   write it only while the block is idle.
// Throughput:
//   One text byte is accepted per cycle while full is low. The front decodes
//   it in that cycle and registers its results (up to three data bytes plus a
//   status on message end) as one packet in the queue. The back end emits one
//   result per cycle while pop is high; bytes that produce nothing
//   (whitespace, skipped text) push no packet. A four-packet queue between
//   front and back absorbs bursts.
// Reset and stall:
//   Reset clears the decode state, the delimiter and the queue. When the
//   receiver stops popping, the queue fills and full rises until space frees.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder_top
  import b64d_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  in_item_t   in_item_i,
  input  logic       push,
  output logic       full,
  output out_item_t  out_item_o,
  output logic       empty,
  input  logic       pop
);

  logic accept;
  logic pkt_valid;
  logic pkt_done;
  pkt_t pkt;
  pkt_t head;

  assign accept = push && !full;

  // Front: decode
  b64d_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .pkt_valid_o(pkt_valid),
    .pkt_o      (pkt)
  );

  // Packet queue
  b64d_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (pkt_valid),
    .pkt_i  (pkt),
    .pop_i  (pkt_done),
    .full_o (full),
    .empty_o(empty),
    .head_o (head)
  );

  // Back: emit results
  b64d_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .head_i    (head),
    .pop_i     (pop),
    .pkt_done_o(pkt_done),
    .item_o    (out_item_o)
  );

endmodule

`default_nettype wire

/* rtl/b64d_front.sv */
// Front end of the Base64 decoder: classifies each text byte, runs the
// decode state and builds one packet of results per item. Uses b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_front
  import b64d_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       accept_i,
  input  in_item_t   item_i,
  output logic       pkt_valid_o,
  output pkt_t       pkt_o
);

  logic [7:0]             delim_q;
  logic [23:0]            acc_q, acc_d;
  logic [1:0]             phase_q, phase_d;
  logic [1:0]             mode_q, mode_d;
  logic [OFFSET_BITS-1:0] ofs_q, ofs_d;
  logic [OFFSET_BITS-1:0] stop_q, stop_d;

  logic [7:0]             cls;
  logic [23:0]            shifted;
  logic [OFFSET_BITS-1:0] nxt;
  logic [OFFSET_BITS-1:0] where;
  logic                   is_pad;
  pkt_t                   pkt;

  // Decode one item
  always_comb begin
    cls     = b64d_classify(item_i.text_byte);
    shifted = {acc_q[17:0], cls[5:0]};
    nxt     = ofs_q + 1'b1;
    is_pad  = (item_i.text_byte == PAD_CHAR);
    acc_d   = acc_q;
    phase_d = phase_q;
    mode_d  = mode_q;
    stop_d  = stop_q;
    ofs_d   = nxt;
    where   = stop_q;
    pkt     = '0;

    unique case (mode_q)
      MODE_SCAN: begin
        priority if (delim_q != 8'h00 && item_i.text_byte == delim_q) begin
          mode_d = (phase_q != 2'd0) ? MODE_ERR : MODE_OK;
          stop_d = ofs_q;
        end else if (is_pad) begin
          stop_d = nxt;
          if (phase_q == 2'd3) begin
            pkt.data[0] = acc_q[17:10];
            pkt.data[1] = acc_q[9:2];
            pkt.n_data  = 2'd2;
            mode_d      = MODE_OK;
          end else if (phase_q == 2'd2) begin
            mode_d = MODE_SEEK;
          end else begin
            mode_d = MODE_ERR;
          end
        end else if (cls == CLS_ERROR) begin
          mode_d = MODE_ERR;
          stop_d = ofs_q;
        end else if (cls != CLS_SPACE) begin
          if (phase_q == 2'd3) begin
            pkt.data[0] = shifted[23:16];
            pkt.data[1] = shifted[15:8];
            pkt.data[2] = shifted[7:0];
            pkt.n_data  = 2'd3;
            acc_d       = '0;
            phase_d     = 2'd0;
          end else begin
            acc_d   = shifted;
            phase_d = phase_q + 2'd1;
          end
        end else begin
          acc_d = acc_q;
        end
      end
      MODE_SEEK: begin
        if (is_pad) begin
          pkt.data[0] = acc_q[11:4];
          pkt.n_data  = 2'd1;
          mode_d      = MODE_OK;
          stop_d      = nxt;
        end
      end
      MODE_OK, MODE_ERR: begin
        mode_d = mode_q;
      end
    endcase

    // Message end: status result and fresh state
    if (item_i.message_end) begin
      unique case (mode_d)
        MODE_SCAN: begin
          pkt.status_kind = (phase_d != 2'd0) ? KIND_ERR : KIND_OK;
          where           = nxt;
        end
        MODE_OK: begin
          pkt.status_kind = KIND_OK;
          where           = stop_d;
        end
        MODE_SEEK, MODE_ERR: begin
          pkt.status_kind = KIND_ERR;
          where           = stop_d;
        end
      endcase
      pkt.has_status = 1'b1;
      pkt.status_pos = POS_W'(where);
      acc_d   = '0;
      phase_d = 2'd0;
      mode_d  = MODE_SCAN;
      ofs_d   = '0;
      stop_d  = '0;
    end
  end

  assign pkt_o       = pkt;
  assign pkt_valid_o = accept_i && (pkt.n_data != 2'd0 || pkt.has_status);

  // Decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      phase_q <= 2'd0;
      mode_q  <= MODE_SCAN;
      ofs_q   <= '0;
      stop_q  <= '0;
    end else if (accept_i) begin
      acc_q   <= acc_d;
      phase_q <= phase_d;
      mode_q  <= mode_d;
      ofs_q   <= ofs_d;
      stop_q  <= stop_d;
    end
  end

  // Delimiter register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= 8'h00;
    end else if (cfg_we_i) begin
      delim_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/b64d_queue.sv */
// Short packet queue between decoder front and result back end.
// Register based, one write and one head read per cycle. Uses b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue
  import b64d_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pkt_t pkt_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output pkt_t head_o
);

  pkt_t            mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_q, rd_q;
  logic [Q_AW:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= pkt_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count above depth");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not grow on push");
`endif

endmodule

`default_nettype wire

/* rtl/b64d_back.sv */
// Result back end: walks the head packet and presents its results one
// per cycle while pop is high, oldest first. Uses b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  pkt_t      head_i,
  input  logic      pop_i,
  output logic      pkt_done_o,
  output out_item_t item_o
);

  logic [1:0] idx_q, idx_d;
  logic [2:0] total;
  logic       is_data;
  logic       last;

  assign total   = {1'b0, head_i.n_data} + {2'b00, head_i.has_status};
  assign is_data = ({1'b0, idx_q} < {1'b0, head_i.n_data});
  assign last    = ({1'b0, idx_q} + 3'd1 == total);

  // Current result
  always_comb begin
    item_o             = '0;
    item_o.last_of_run = last;
    if (is_data) begin
      item_o.data_byte = head_i.data[idx_q];
      item_o.kind      = KIND_DATA;
    end else begin
      item_o.kind          = head_i.status_kind;
      item_o.stop_position = head_i.status_pos;
    end
  end

  assign pkt_done_o = pop_i && !empty_i && last;

  always_comb begin
    idx_d = idx_q;
    if (pop_i && !empty_i) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef SYNTH
  a_pkt_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (head_i.n_data != 2'd0 || head_i.has_status))
    else $error("queued packet carries no result");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> ({1'b0, idx_q} < total))
    else $error("result index past packet end");
`endif

endmodule

`default_nettype wire
